>>> hdl/ocl_pkg.sv
// Shared types, constants and codes for the octree point locator.
`timescale 1ns / 1ps

package ocl_pkg;

  // Table sizes and descent limit
  localparam int NODE_DEPTH  = 1024;
  localparam int FLOOR_DEPTH = 4096;
  localparam int LEVELS      = 31;
  localparam int COORD_BITS  = 31;

  // Field widths
  localparam int MODE_W  = 2;
  localparam int ADDR_W  = 12;
  localparam int SLOT_W  = 3;
  localparam int WORD_W  = 32;
  localparam int ID_W    = 14;
  localparam int ROOT_W  = 13;
  localparam int DIMS_W  = 2;
  localparam int START_W = 13;
  localparam int COUNT_W = 12;

  localparam int NODE_AW     = $clog2(NODE_DEPTH);
  localparam int NODE_MEM_AW = NODE_AW + SLOT_W;
  localparam int NODE_WORDS  = NODE_DEPTH * 8;
  localparam int FLOOR_AW    = $clog2(FLOOR_DEPTH);
  localparam int LEVEL_W     = $clog2(LEVELS + 1);

  // Stream packing
  localparam int IN_BITS    = ADDR_W + SLOT_W + WORD_W + 3 * COORD_BITS;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = START_W + COUNT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 2;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_NODE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FLOOR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  // Configuration register indexes
  localparam logic CFG_DIMS = 1'b0;
  localparam logic CFG_ROOT = 1'b1;

  localparam logic [DIMS_W-1:0] DIMS_RESET = 2'd3;

  typedef struct packed {
    logic [COORD_BITS-1:0] z;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] x;
    logic [WORD_W-1:0]     word;
    logic [SLOT_W-1:0]     slot;
    logic [ADDR_W-1:0]     address;
  } in_item_t;

  typedef enum logic [1:0] {
    EMIT_EMPTY,
    EMIT_DERR,
    EMIT_FLOOR
  } emit_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DESCEND,
    ST_FLOOR
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic  load;
    logic  node_rd;
    logic  floor_rd;
    logic  emit;
    emit_t emit_kind;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic id_pos;
    logic id_neg;
    logic level_max;
    logic node_oob;
    logic floor_oob;
    logic out_free;
  } status_t;

endpackage

>>> hdl/ocl_ctrl.sv
// Descent controller: sequences the node reads, the floor read and the result beat.
`timescale 1ns / 1ps

module ocl_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_accept,
  input  logic [ocl_pkg::MODE_W-1:0]    in_mode,
  input  ocl_pkg::status_t              status,
  output ocl_pkg::cmd_t                 cmd,
  output logic                          in_ready
);

  ocl_pkg::state_t state, state_next;

  logic descend_on;
  logic floor_go;

  assign descend_on = status.id_pos && !status.level_max && !status.node_oob;
  assign floor_go   = status.id_neg && !status.floor_oob;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ocl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ocl_pkg::ST_IDLE: begin
        if (in_accept && in_mode == ocl_pkg::MODE_QUERY) state_next = ocl_pkg::ST_DESCEND;
      end
      ocl_pkg::ST_DESCEND: begin
        if (descend_on) begin
          state_next = ocl_pkg::ST_DESCEND;
        end else if (floor_go) begin
          state_next = ocl_pkg::ST_FLOOR;
        end else if (status.out_free) begin
          state_next = ocl_pkg::ST_IDLE;
        end
      end
      ocl_pkg::ST_FLOOR: begin
        if (status.out_free) state_next = ocl_pkg::ST_IDLE;
      end
      default: state_next = ocl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.node_rd   = 1'b0;
    cmd.floor_rd  = 1'b0;
    cmd.emit      = 1'b0;
    cmd.emit_kind = ocl_pkg::EMIT_EMPTY;
    case (state)
      ocl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_accept && in_mode == ocl_pkg::MODE_QUERY;
      end
      ocl_pkg::ST_DESCEND: begin
        if (descend_on) begin
          cmd.node_rd = 1'b1;
        end else if (floor_go) begin
          cmd.floor_rd = 1'b1;
        end else begin
          cmd.emit = status.out_free;
          // still a node after the last level: too deep
          cmd.emit_kind = (status.id_pos && status.level_max) ?
                          ocl_pkg::EMIT_DERR : ocl_pkg::EMIT_EMPTY;
        end
      end
      ocl_pkg::ST_FLOOR: begin
        cmd.emit      = status.out_free;
        cmd.emit_kind = ocl_pkg::EMIT_FLOOR;
      end
      default: in_ready = 1'b0;
    endcase
  end

endmodule

>>> hdl/ocl_dp.sv
// Datapath: config registers, node and floor memories, descent registers, result register.
`timescale 1ns / 1ps

module ocl_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [ocl_pkg::ROOT_W-1:0]        cfg_data,
  input  logic                              in_accept,
  input  logic [ocl_pkg::MODE_W-1:0]        in_mode,
  input  ocl_pkg::in_item_t                 in_item,
  input  ocl_pkg::cmd_t                     cmd,
  output ocl_pkg::status_t                  status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              found,
  output logic                              depth_error,
  output logic [ocl_pkg::START_W-1:0]       list_start,
  output logic [ocl_pkg::COUNT_W-1:0]       list_count
);

  logic [ocl_pkg::DIMS_W-1:0]   dims;
  logic signed [ocl_pkg::ROOT_W-1:0] root_id;

  logic [ocl_pkg::ID_W-1:0]     node_mem [ocl_pkg::NODE_WORDS];
  logic [ocl_pkg::WORD_W-1:0]   floor_mem [ocl_pkg::FLOOR_DEPTH];

  logic [ocl_pkg::ID_W-1:0]     node_q;
  logic [ocl_pkg::WORD_W-1:0]   floor_q;
  logic [ocl_pkg::ID_W-1:0]     id_reg;
  logic                         from_mem;
  logic [ocl_pkg::LEVEL_W-1:0]  level;
  logic [ocl_pkg::COORD_BITS-1:0] x_sh, y_sh, z_sh;
  logic [ocl_pkg::FLOOR_AW-1:0] fidx;

  logic [ocl_pkg::ID_W-1:0]     cur_id;
  logic [ocl_pkg::ID_W-1:0]     node_idx;
  logic [ocl_pkg::ID_W-1:0]     fidx_full;
  logic [ocl_pkg::SLOT_W-1:0]   slot_sel;
  logic [ocl_pkg::NODE_MEM_AW-1:0] rd_addr;
  logic                         node_we, floor_we;
  logic [ocl_pkg::COUNT_W-1:0]  count_sat;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dims    <= ocl_pkg::DIMS_RESET;
      root_id <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ocl_pkg::CFG_DIMS: dims    <= cfg_data[ocl_pkg::DIMS_W-1:0];
        ocl_pkg::CFG_ROOT: root_id <= cfg_data;
        default:           dims    <= dims;
      endcase
    end
  end

  // table writes, out-of-range addresses dropped
  assign node_we  = in_accept && in_mode == ocl_pkg::MODE_NODE &&
                    ({1'b0, in_item.address} < (ocl_pkg::ADDR_W + 1)'(ocl_pkg::NODE_DEPTH));
  assign floor_we = in_accept && in_mode == ocl_pkg::MODE_FLOOR &&
                    ({1'b0, in_item.address} < (ocl_pkg::ADDR_W + 1)'(ocl_pkg::FLOOR_DEPTH));

  assign cur_id    = from_mem ? node_q : id_reg;
  assign node_idx  = cur_id - ocl_pkg::ID_W'(1);
  assign fidx_full = ~cur_id;  // -id-1
  assign slot_sel  = {z_sh[ocl_pkg::COORD_BITS-1], y_sh[ocl_pkg::COORD_BITS-1],
                      x_sh[ocl_pkg::COORD_BITS-1]};
  assign rd_addr   = {node_idx[ocl_pkg::NODE_AW-1:0], slot_sel};

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[{in_item.address[ocl_pkg::NODE_AW-1:0], in_item.slot}] <=
        in_item.word[ocl_pkg::ID_W-1:0];
    end
    if (cmd.node_rd) begin
      node_q <= node_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (floor_we) begin
      floor_mem[in_item.address[ocl_pkg::FLOOR_AW-1:0]] <= in_item.word;
    end
    if (cmd.floor_rd) begin
      floor_q <= floor_mem[fidx_full[ocl_pkg::FLOOR_AW-1:0]];
    end
  end

  // descent registers; coordinates shift up so the MSB is the current bit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_reg   <= {root_id[ocl_pkg::ROOT_W-1], root_id};
      from_mem <= 1'b0;
      level    <= '0;
      x_sh     <= in_item.x;
      y_sh     <= (dims >= 2'd2) ? in_item.y : '0;
      z_sh     <= (dims == 2'd3) ? in_item.z : '0;
    end else if (cmd.node_rd) begin
      from_mem <= 1'b1;
      level    <= level + ocl_pkg::LEVEL_W'(1);
      x_sh     <= {x_sh[ocl_pkg::COORD_BITS-2:0], 1'b0};
      y_sh     <= {y_sh[ocl_pkg::COORD_BITS-2:0], 1'b0};
      z_sh     <= {z_sh[ocl_pkg::COORD_BITS-2:0], 1'b0};
    end
    if (cmd.floor_rd) begin
      fidx <= fidx_full[ocl_pkg::FLOOR_AW-1:0];
    end
  end

  assign status.id_pos    = !cur_id[ocl_pkg::ID_W-1] && (cur_id != '0);
  assign status.id_neg    = cur_id[ocl_pkg::ID_W-1];
  assign status.level_max = (level == ocl_pkg::LEVEL_W'(ocl_pkg::LEVELS));
  assign status.node_oob  = (node_idx >= ocl_pkg::ID_W'(ocl_pkg::NODE_DEPTH));
  assign status.floor_oob = (fidx_full >= ocl_pkg::ID_W'(ocl_pkg::FLOOR_DEPTH));
  assign status.out_free  = !out_valid || out_ready;

  // count saturates to [0, 4095]
  always_comb begin
    if (floor_q[ocl_pkg::WORD_W-1]) begin
      count_sat = '0;
    end else if (floor_q[ocl_pkg::WORD_W-2:ocl_pkg::COUNT_W] != '0) begin
      count_sat = '1;
    end else begin
      count_sat = floor_q[ocl_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      found       <= (cmd.emit_kind == ocl_pkg::EMIT_FLOOR);
      depth_error <= (cmd.emit_kind == ocl_pkg::EMIT_DERR);
      list_start  <= (cmd.emit_kind == ocl_pkg::EMIT_FLOOR) ?
                     ocl_pkg::START_W'(fidx) + ocl_pkg::START_W'(1) : '0;
      list_count  <= (cmd.emit_kind == ocl_pkg::EMIT_FLOOR) ? count_sat : '0;
    end
  end

endmodule

>>> hdl/octree_point_locator.sv
// Top level of the octree point locator: stream ports, controller and datapath.
`timescale 1ns / 1ps

// Octree point locator. Input beats either load the tables (tuser mode 0 writes one
// child id of a node, mode 1 writes one floor table word) or ask a point query
// (mode 2); mode 3 is dropped. Table writes give no result. A query walks down from
// root_id, one registered node memory read per level. A query that ends on a floor
// takes the beat, reads one node per level passed (at most 31), reads the floor
// count, then loads the result register. An empty or too-deep result skips the
// floor read. The result register may then wait on m_tready. Tables have no reset
// and must be written before they are read. Config (dims, root_id) is written
// through cfg_we/cfg_index/cfg_data; the user must do so only while no query is in
// flight, as the block itself does not enforce it. The result register lets the next
// beat be taken while a result waits on m_tready.

module octree_point_locator (
  input  logic                                clk,
  input  logic                                rst,
  // config write port
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [ocl_pkg::ROOT_W-1:0]          cfg_data,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // address[11:0], slot[14:12], word[46:15], x[77:47], y[108:78], z[139:109], zero pad
  input  logic [ocl_pkg::IN_TDATA_W-1:0]      s_tdata,
  // mode[1:0]
  input  logic [ocl_pkg::MODE_W-1:0]          s_tuser,
  // output stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // list_start[12:0], list_count[24:13], zero pad
  output logic [ocl_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // found[0], depth_error[1]
  output logic [ocl_pkg::OUT_TUSER_W-1:0]     m_tuser
);

  ocl_pkg::in_item_t in_item;
  ocl_pkg::cmd_t     cmd;
  ocl_pkg::status_t  status;

  logic                          in_accept;
  logic                          found;
  logic                          depth_error;
  logic [ocl_pkg::START_W-1:0]   list_start;
  logic [ocl_pkg::COUNT_W-1:0]   list_count;

  assign in_accept = s_tvalid && s_tready;
  assign in_item   = s_tdata[ocl_pkg::IN_BITS-1:0];

  ocl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .in_mode   (s_tuser),
    .status    (status),
    .cmd       (cmd),
    .in_ready  (s_tready)
  );

  ocl_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_accept   (in_accept),
    .in_mode     (s_tuser),
    .in_item     (in_item),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .found       (found),
    .depth_error (depth_error),
    .list_start  (list_start),
    .list_count  (list_count)
  );

  // result packing
  assign m_tdata = {{(ocl_pkg::OUT_TDATA_W - ocl_pkg::OUT_BITS){1'b0}}, list_count, list_start};
  assign m_tuser = {depth_error, found};

endmodule

>>> tb/testbench.sv
// Self-checking testbench for octree_point_locator: table loads, point queries, config phases.
`timescale 1ns / 1ps

module testbench;
  import ocl_pkg::*;

  // Mode 3 has no name in the package; the block drops it.
  localparam logic [MODE_W-1:0] MODE_SKIP = 2'd3;

  localparam logic [COORD_BITS-1:0] COORD_MAX = '1;
  localparam int ID_MAX   = (1 << (ID_W - 1)) - 1;    // largest child id a node can hold
  localparam int ROOT_MAX = (1 << (ROOT_W - 1)) - 1;
  localparam int COUNT_MAX = (1 << COUNT_W) - 1;

  // Worst query: take beat, LEVELS node reads, floor read, result load. Pad generously.
  localparam int SETTLE_CYCLES  = LEVELS + 16;
  localparam int HOLD_CYCLES    = 300;    // long receiver stall, fills the block
  localparam int WATCHDOG_LIMIT = 3000;   // cycles with no beat on either side
  localparam int PHASE_ITEMS    = 80;

  // One locate result as the block reports it.
  typedef struct packed {
    logic               found;
    logic [START_W-1:0] start;
    logic [COUNT_W-1:0] count;
    logic               derr;
  } leaf_t;

  // Mirror of the block's tables and registers; predicts each query's leaf.
  class octree_mirror;
    logic [DIMS_W-1:0]        dims;
    logic signed [ROOT_W-1:0] root;
    logic signed [ID_W-1:0]   node_tab [NODE_WORDS];
    logic [WORD_W-1:0]        floor_tab [FLOOR_DEPTH];
    leaf_t                    leaves_due [$];
    int                       errors;

    function new();
      dims   = DIMS_RESET;
      root   = '0;
      errors = 0;
    endfunction

    function void set_reg(logic idx, logic [ROOT_W-1:0] data);
      if (idx == CFG_DIMS) dims = data[DIMS_W-1:0];
      else root = data;
    endfunction

    function leaf_t walk_to_leaf(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                                 logic [COORD_BITS-1:0] z);
      leaf_t                    r;
      int                       id;
      int                       lvl;
      int                       b;
      int                       fidx;
      logic [2:0]               sel;
      logic signed [WORD_W-1:0] n;
      r = '0;
      if (dims < 2) y = '0;
      if (dims < 3) z = '0;
      id  = int'(root);
      lvl = 0;
      while (id > 0 && lvl < LEVELS) begin
        if (id - 1 >= NODE_DEPTH) begin
          id = 0;                          // node past the table reads as empty
        end else begin
          b   = COORD_BITS - 1 - lvl;
          sel = (b >= 0) ? {z[b], y[b], x[b]} : 3'b000;
          id  = int'(node_tab[(id - 1) * 8 + int'(sel)]);
          lvl++;
        end
      end
      if (id > 0) begin
        r.derr = 1'b1;                     // still on a node after the last level
      end else if (id < 0) begin
        fidx = -id - 1;
        if (fidx < FLOOR_DEPTH) begin
          n       = floor_tab[fidx];
          r.found = 1'b1;
          r.start = START_W'(fidx + 1);
          if (n < 0) r.count = '0;
          else if (n > COUNT_MAX) r.count = '1;
          else r.count = n[COUNT_W-1:0];
        end
      end
      return r;
    endfunction

    function void take_beat(logic [MODE_W-1:0] mode, logic [IN_TDATA_W-1:0] tdata);
      in_item_t it;
      it = in_item_t'(tdata[IN_BITS-1:0]);
      case (mode)
        MODE_NODE:
          if (it.address < NODE_DEPTH)
            node_tab[int'(it.address) * 8 + int'(it.slot)] = it.word[ID_W-1:0];
        MODE_FLOOR:
          if (it.address < FLOOR_DEPTH) floor_tab[it.address] = it.word;
        MODE_QUERY: leaves_due.push_back(walk_to_leaf(it.x, it.y, it.z));
        default: ;
      endcase
    endfunction

    // Fields printed as found/start/count/depth_error.
    function void check_leaf(logic [OUT_TDATA_W-1:0] tdata, logic [OUT_TUSER_W-1:0] tuser);
      leaf_t got;
      leaf_t want;
      got.found = tuser[0];
      got.derr  = tuser[1];
      got.start = tdata[START_W-1:0];
      got.count = tdata[START_W +: COUNT_W];
      if (leaves_due.size() == 0) begin
        errors++;
        $display("%0t leaf mismatch: expected none, got %b/%0d/%0d/%b",
                 $time, got.found, got.start, got.count, got.derr);
      end else begin
        want = leaves_due.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t leaf mismatch: expected %b/%0d/%0d/%b, got %b/%0d/%0d/%b",
                   $time, want.found, want.start, want.count, want.derr,
                   got.found, got.start, got.count, got.derr);
        end
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic                   cfg_index;
  logic [ROOT_W-1:0]      cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // address, slot, word, x, y, z from bit 0 up, zero pad
  logic [MODE_W-1:0]      s_tuser;   // mode
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // list_start, list_count from bit 0 up, zero pad
  logic [OUT_TUSER_W-1:0] m_tuser;   // found, depth_error from bit 0 up

  octree_mirror mirror;
  bit           calm;         // end of run: no idling on either side
  bit           hold_req;     // asks the receiver for one long stall
  int           gap_pct;      // chance of a sender gap before a beat
  int           quiet;
  bit           node_live [NODE_DEPTH];
  bit           floor_live [FLOOR_DEPTH];
  int           live_nodes [$];    // nodes with all eight children written
  int           live_floors [$];   // floor entries written at least once

  octree_point_locator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Beat monitor. Runs in the active region of the edge, so it sees the values the
  // block saw. Result check goes first; a query never completes at its own edge anyway.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) mirror.set_reg(cfg_index, cfg_data);
      if (m_tvalid && m_tready) mirror.check_leaf(m_tdata, m_tuser);
      if (s_tvalid && s_tready) mirror.take_beat(s_tuser, s_tdata);
    end
  end

  // Watchdog: too long without a beat on either side means a hang.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Receiver: ready in random stretches, random stalls between them, one long hold on request.
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 12)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(0, 19)) @(posedge clk);
      end
    end
  end

  function automatic in_item_t rand_item();
    in_item_t it;
    it.address = ADDR_W'($urandom);
    it.slot    = SLOT_W'($urandom);
    it.word    = $urandom;
    it.x       = COORD_BITS'($urandom);
    it.y       = COORD_BITS'($urandom);
    it.z       = COORD_BITS'($urandom);
    return it;
  endfunction

  // Child id for a node write. Only ids that lead to written entries, past the tables, or empty (0).
  function automatic int pick_child(int node_w);
    int r;
    r = $urandom_range(0, 99);
    if (r < node_w) return live_nodes[$urandom_range(0, live_nodes.size() - 1)] + 1;
    if (r < node_w + 25) return -(live_floors[$urandom_range(0, live_floors.size() - 1)] + 1);
    if (r < node_w + 35) return int'($urandom_range(NODE_DEPTH + 1, ID_MAX));
    if (r < node_w + 45) return -int'($urandom_range(FLOOR_DEPTH + 1, ID_MAX + 1));
    return 0;
  endfunction

  function automatic int pick_root();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return -(live_floors[$urandom_range(0, live_floors.size() - 1)] + 1);
      2:       return int'($urandom_range(NODE_DEPTH + 1, ROOT_MAX));
      3:       return NODE_DEPTH;
      default: return live_nodes[$urandom_range(0, live_nodes.size() - 1)] + 1;
    endcase
  endfunction

  // Floor word: mostly small counts, some near the clamp, some anything at all.
  function automatic logic [WORD_W-1:0] rand_count_word();
    case ($urandom_range(0, 5))
      0, 1, 2: return $urandom_range(0, 40);
      3:       return $urandom_range(COUNT_MAX - 5, COUNT_MAX + 5);
      default: return $urandom;
    endcase
  endfunction

  // One input beat; returns at the edge where it is taken. tvalid stays up afterwards.
  task automatic send_item(input logic [MODE_W-1:0] mode, input in_item_t it);
    int pause;
    if (!calm && $urandom_range(1, 100) <= gap_pct) begin
      pause = $urandom_range(1, 13);
      s_tvalid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= IN_TDATA_W'(it);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_query(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                            input logic [COORD_BITS-1:0] z);
    in_item_t it;
    it   = rand_item();
    it.x = x;
    it.y = y;
    it.z = z;
    send_item(MODE_QUERY, it);
  endtask

  task automatic put_child(input int addr, input int sl, input int child);
    in_item_t it;
    it                = rand_item();   // upper word bits are random, only 14 are kept
    it.address        = ADDR_W'(addr);
    it.slot           = SLOT_W'(sl);
    it.word[ID_W-1:0] = ID_W'(child);
    send_item(MODE_NODE, it);
  endtask

  task automatic build_node(input int n, input int node_w);
    for (int sl = 0; sl < 8; sl++) put_child(n, sl, pick_child(node_w));
    if (!node_live[n]) begin
      node_live[n] = 1'b1;
      live_nodes.push_back(n);
    end
  endtask

  task automatic put_floor(input int f, input logic [WORD_W-1:0] w);
    in_item_t it;
    it         = rand_item();
    it.address = ADDR_W'(f);
    it.word    = w;
    send_item(MODE_FLOOR, it);
    if (!floor_live[f]) begin
      floor_live[f] = 1'b1;
      live_floors.push_back(f);
    end
  endtask

  // Stop offering, wait out every pending result, then let trailing writes finish.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (mirror.leaves_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both registers, only with the block idle.
  task automatic configure(input logic [DIMS_W-1:0] d, input int r);
    logic [ROOT_W-1:0] v;
    drain();
    v             = ROOT_W'($urandom);  // bits above dims are don't care
    v[DIMS_W-1:0] = d;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DIMS;
    cfg_data  <= v;
    @(posedge clk);
    cfg_index <= CFG_ROOT;
    cfg_data  <= ROOT_W'(r);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_item();
    in_item_t it;
    int       r;
    it = rand_item();
    r  = $urandom_range(0, 99);
    if (r < 55) begin
      // mostly random points, now and then a corner of the cube
      if ($urandom_range(0, 7) == 0) it.x = ($urandom_range(0, 1) == 1) ? COORD_MAX : '0;
      if ($urandom_range(0, 7) == 0) it.y = ($urandom_range(0, 1) == 1) ? COORD_MAX : '0;
      if ($urandom_range(0, 7) == 0) it.z = ($urandom_range(0, 1) == 1) ? COORD_MAX : '0;
      send_item(MODE_QUERY, it);
    end else if (r < 78) begin
      put_child(live_nodes[$urandom_range(0, live_nodes.size() - 1)],
                $urandom_range(0, 7), pick_child(50));
    end else if (r < 81) begin
      build_node($urandom_range(0, NODE_DEPTH - 1), 50);
    end else if (r < 88) begin
      put_floor($urandom_range(0, FLOOR_DEPTH - 1), rand_count_word());
    end else if (r < 94) begin
      // dropped by the block
      it.address = ADDR_W'($urandom_range(NODE_DEPTH, (1 << ADDR_W) - 1));
      send_item(MODE_NODE, it);
    end else begin
      send_item(MODE_SKIP, it);
    end
  endtask

  initial begin
    mirror    = new();
    calm      = 1'b0;
    hold_req  = 1'b0;
    gap_pct   = 15;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_DIMS;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= MODE_NODE;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // --- directed part ---
    send_query('0, '0, '0);                      // reset root: empty
    put_floor(0, 32'h8000_0000);                 // negative count reads as 0
    put_floor(1, COUNT_MAX);
    put_floor(2, COUNT_MAX + 1);                 // clamps to 4095
    put_floor(FLOOR_DEPTH - 1, 32'h7fff_ffff);   // last entry, list start 4096
    // last node: one kind of child per slot; slot 5 loops back to itself
    put_child(NODE_DEPTH - 1, 0, -FLOOR_DEPTH);
    put_child(NODE_DEPTH - 1, 1, -1);
    put_child(NODE_DEPTH - 1, 2, 0);
    put_child(NODE_DEPTH - 1, 3, ID_MAX);                  // node past the table
    put_child(NODE_DEPTH - 1, 4, -(ID_MAX + 1));           // floor past the table
    put_child(NODE_DEPTH - 1, 5, NODE_DEPTH);
    put_child(NODE_DEPTH - 1, 6, -2);
    put_child(NODE_DEPTH - 1, 7, -3);
    node_live[NODE_DEPTH - 1] = 1'b1;
    live_nodes.push_back(NODE_DEPTH - 1);
    put_child((1 << ADDR_W) - 1, 0, 1);          // node write past the table: dropped
    send_item(MODE_SKIP, rand_item());

    configure(2'd3, NODE_DEPTH);
    send_query('0, '0, '0);                      // last floor entry
    send_query(COORD_MAX, COORD_MAX, COORD_MAX); // count clamp
    send_query('0, '0, COORD_MAX);               // floor id past the table
    send_query(COORD_MAX, '0, COORD_MAX);        // self loop: runs out of levels
    send_query('0, COORD_MAX, COORD_MAX);
    configure(2'd2, NODE_DEPTH);
    send_query(COORD_MAX, COORD_MAX, COORD_MAX); // z ignored: node past the table
    configure(2'd1, NODE_DEPTH);
    send_query(COORD_MAX, COORD_MAX, COORD_MAX); // y, z ignored: negative count
    configure(2'd0, NODE_DEPTH);
    send_query(COORD_MAX, COORD_MAX, COORD_MAX); // dims 0 acts as 1
    configure(2'd3, -FLOOR_DEPTH);               // root is a floor
    send_query(COORD_MAX, '0, COORD_MAX);
    configure(2'd3, ROOT_MAX);                   // root node past the table
    send_query(COORD_MAX, COORD_MAX, COORD_MAX);

    // --- random part: load tables, then mixed phases under several settings ---
    repeat (40) put_floor($urandom_range(0, FLOOR_DEPTH - 1), rand_count_word());
    repeat (40) build_node($urandom_range(0, NODE_DEPTH - 1), 45);
    for (int ph = 0; ph < 8; ph++) begin
      calm    = (ph == 7);
      gap_pct = (ph % 3 == 0) ? 0 : 25;
      configure(DIMS_W'($urandom_range(0, 3)), pick_root());
      if (ph == 2) hold_req = 1'b1;   // receiver goes quiet while beats keep coming
      repeat (PHASE_ITEMS) random_item();
    end

    drain();
    if (mirror.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/ocl_pkg.sv
hdl/ocl_ctrl.sv
hdl/ocl_dp.sv
hdl/octree_point_locator.sv
tb/testbench.sv
